FILE: rtl/q_table_update_engine_assert.svh
// Assertion macros for the Q-table update engine.
// Used by the top level only; no other dependencies.
`ifndef Q_TABLE_UPDATE_ENGINE_ASSERT_SVH
`define Q_TABLE_UPDATE_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define QTUE_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("qtue: forbidden condition seen");
`define QTUE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qtue: implication failed");
`define QTUE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qtue: next-cycle implication failed");
`else
`define QTUE_ASSERT_NEVER(lbl, clk, rst, cond)
`define QTUE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define QTUE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/qtue_pkg.sv
// Shared types and constants for the Q-table update engine.
// No dependencies.
package qtue_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 2'd3;

  localparam logic [16:0] ONE_Q16          = 17'd65536;
  localparam logic [16:0] LEARN_RATE_RESET = 17'd6554;
  localparam logic [16:0] DISCOUNT_RESET   = 17'd58982;
  localparam int          ACTION_RESET     = 8;
  localparam int          STATE_RESET      = 1024;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [9:0]         cur_state;
    logic [2:0]         taken_action;
    logic signed [31:0] reward;
    logic [9:0]         next_state;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic [2:0]         best_next_action;
    logic               index_error;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic scan_step;
    logic cell_rd;
    logic mul1;
    logic diff;
    logic mul2;
    logic wb;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_err;
    logic clr_last;
    logic scan_last;
  } status_t;

endpackage

FILE: rtl/qtue_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module qtue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/qtue_dp.sv
// Datapath: config registers, table RAM, row scan, update arithmetic, result register.
// Depends on qtue_pkg and qtue_ram.
module qtue_dp
  import qtue_pkg::*;
#(
  parameter int MAX_STATES  = 1024,
  parameter int MAX_ACTIONS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item_data,
  input  cmd_t                  cmd,
  output status_t               st,
  output result_t               result_data
);

  localparam int DEPTH  = MAX_STATES * MAX_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACT_RST = (ACTION_RESET > MAX_ACTIONS) ? MAX_ACTIONS : ACTION_RESET;
  localparam int ST_RST  = (STATE_RESET > MAX_STATES) ? MAX_STATES : STATE_RESET;

  // config, held already capped to capacity and to 1.0
  logic [3:0]  action_eff;
  logic [10:0] state_eff;
  logic [16:0] alpha;
  logic [16:0] gamma;

  // item context
  logic [ADDR_W-1:0]  row_base;
  logic [ADDR_W-1:0]  cell_addr;
  logic signed [31:0] reward;
  logic               err;

  logic [ADDR_W-1:0]  clr_cnt;
  logic [3:0]         scan_cnt;
  logic [3:0]         scan_idx;
  logic               scan_pend;
  logic               cell_pend;

  logic signed [31:0] maxv;
  logic [2:0]         best;
  logic signed [31:0] q;
  logic signed [49:0] prod1;
  logic signed [35:0] d;
  logic signed [53:0] prod2;
  logic signed [31:0] newv;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [31:0]         ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [31:0]         ram_rdata;
  logic signed [37:0]  sum;
  logic [31:0]         sat_val;

  // config writes, capped on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      action_eff <= 4'(ACT_RST);
      state_eff  <= 11'(ST_RST);
      alpha      <= LEARN_RATE_RESET;
      gamma      <= DISCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTION_COUNT: begin
          action_eff <= (32'(cfg_data[3:0]) > 32'(MAX_ACTIONS)) ?
                        4'(MAX_ACTIONS) : cfg_data[3:0];
        end
        CFG_STATE_COUNT: begin
          state_eff <= (32'(cfg_data[10:0]) > 32'(MAX_STATES)) ?
                       11'(MAX_STATES) : cfg_data[10:0];
        end
        CFG_LEARN_RATE: begin
          alpha <= (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
        end
        CFG_DISCOUNT: begin
          gamma <= (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // index check on the incoming request
  always_comb begin
    st.in_err = !(({1'b0, item_data.cur_state} < state_eff) &&
                  ({1'b0, item_data.next_state} < state_eff) &&
                  ({1'b0, item_data.taken_action} < action_eff));
    st.clr_last  = (clr_cnt == ADDR_W'(DEPTH - 1));
    st.scan_last = (scan_cnt == action_eff - 4'd1);
  end

  // control-side counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      scan_cnt  <= '0;
      scan_pend <= 1'b0;
      cell_pend <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.load) begin
        scan_cnt <= '0;
      end else if (cmd.scan_step) begin
        scan_cnt <= scan_cnt + 4'd1;
      end
      scan_pend <= cmd.scan_step;
      cell_pend <= cmd.cell_rd;
    end
  end

  // table access
  always_comb begin
    ram_re    = cmd.scan_step || cmd.cell_rd;
    ram_raddr = cmd.cell_rd ? cell_addr : row_base + ADDR_W'(scan_cnt);
    ram_we    = cmd.clr_step || cmd.wb;
    ram_waddr = cmd.clr_step ? clr_cnt : cell_addr;
    ram_wdata = cmd.clr_step ? 32'd0 : sat_val;
  end

  qtue_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // final add and saturate
  always_comb begin
    sum = 38'(q) + 38'(prod2 >>> 16);
    if ((sum[37:31] == 7'h00) || (sum[37:31] == 7'h7F)) begin
      sat_val = sum[31:0];
    end else begin
      sat_val = sum[37] ? SAT_NEG : SAT_POS;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_base  <= ADDR_W'(item_data.next_state) * ADDR_W'(MAX_ACTIONS);
      cell_addr <= ADDR_W'(item_data.cur_state) * ADDR_W'(MAX_ACTIONS)
                   + ADDR_W'(item_data.taken_action);
      reward    <= item_data.reward;
      err       <= st.in_err;
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_cnt;
    end
    // strict greater keeps the lowest index on ties
    if (scan_pend && ((scan_idx == 4'd0) || ($signed(ram_rdata) > maxv))) begin
      maxv <= $signed(ram_rdata);
      best <= scan_idx[2:0];
    end
    if (cell_pend) begin
      q <= $signed(ram_rdata);
    end
    if (cmd.mul1) begin
      prod1 <= $signed({1'b0, gamma}) * maxv;
    end
    if (cmd.diff) begin
      d <= 36'(reward) + 36'(prod1 >>> 16) - 36'(q);
    end
    if (cmd.mul2) begin
      prod2 <= $signed({1'b0, alpha}) * d;
    end
    if (cmd.wb) begin
      newv <= $signed(sat_val);
    end
    if (cmd.out_load) begin
      if (err) begin
        result_data <= '{new_value: 32'sd0, best_next_action: 3'd0, index_error: 1'b1};
      end else begin
        result_data <= '{new_value: newv, best_next_action: best, index_error: 1'b0};
      end
    end
  end

endmodule

FILE: rtl/qtue_ctrl.sv
// Controller state machine: sequences clear pass, row scan, update and result handoff.
// Depends on qtue_pkg.
module qtue_ctrl
  import qtue_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CELL,
    S_MUL1,
    S_DIFF,
    S_MUL2,
    S_WB,
    S_RESULT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.clr_step  = (state == S_CLEAR);
    cmd.scan_step = (state == S_SCAN);
    cmd.cell_rd   = (state == S_CELL);
    cmd.mul1      = (state == S_MUL1);
    cmd.diff      = (state == S_DIFF);
    cmd.mul2      = (state == S_MUL2);
    cmd.wb        = (state == S_WB);
    cmd.out_load  = (state == S_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (st.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= st.in_err ? S_RESULT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (st.scan_last) begin
            state <= S_CELL;
          end
        end
        S_CELL:   state <= S_MUL1;
        S_MUL1:   state <= S_DIFF;
        S_DIFF:   state <= S_MUL2;
        S_MUL2:   state <= S_WB;
        S_WB:     state <= S_RESULT;
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/q_table_update_engine.sv
// Q-table update engine, top level: controller plus datapath.
// One request at a time: item_stall stays high until the current result is handed to
// the output register; requests with an index error skip the row scan and update.
// The row scan reads one table entry per cycle through the single RAM read port.
// Reset: synchronous, active high; then a clear pass over all MAX_STATES*MAX_ACTIONS entries
// (8192 by default) zeroes the table while item_stall stays high; cfg writes still land.
`include "q_table_update_engine_assert.svh"

module q_table_update_engine
  import qtue_pkg::*;
#(
  parameter int MAX_STATES  = 1024,
  parameter int MAX_ACTIONS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item_data,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result_data,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  // Controller: one request in flight. Sequence per request:
  // scan next-state row (one read per action), read Q(s,a),
  // gamma*max, form the difference, alpha*diff, saturate and write back,
  // then hand the result to the output register; an index error goes straight there.
  qtue_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .st          (st),
    .cmd         (cmd)
  );

  // Datapath: holds config, the table RAM and the arithmetic.
  // The output register lets the next request enter while a result waits.
  qtue_dp #(
    .MAX_STATES (MAX_STATES),
    .MAX_ACTIONS(MAX_ACTIONS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_data  (item_data),
    .cmd        (cmd),
    .st         (st),
    .result_data(result_data)
  );

  // one RAM operation per cycle at most
  `QTUE_ASSERT_IMPL(a_one_ram_op, clk, rst, 1'b1,
                    $onehot0({cmd.clr_step, cmd.scan_step, cmd.cell_rd, cmd.wb}))
  // no request taken while the table is being cleared or written
  `QTUE_ASSERT_NEVER(a_no_accept_busy, clk, rst,
                     item_valid && !item_stall && (cmd.clr_step || cmd.wb))
  // last scan read is followed by the Q(s,a) read
  `QTUE_ASSERT_NEXT(a_scan_to_cell, clk, rst, cmd.scan_step && st.scan_last, cmd.cell_rd)

endmodule

FILE: verif/q_update_checker.sv
// Checker for the Q-table update engine: watches the request, result and config ports.
// Keeps its own value table and register copies, predicts each result and compares.
// Depends on qtue_pkg for the payload types, register indexes and reset values.
`timescale 1ns / 1ps

module q_update_checker
  import qtue_pkg::*;
#(
  parameter int MAX_STATES  = 1024,
  parameter int MAX_ACTIONS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item_data,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    mismatches,
  output int                    results_checked,
  output int                    index_errors
);

  logic signed [31:0] q_values [MAX_STATES*MAX_ACTIONS];
  logic [3:0]         act_cnt;
  logic [10:0]        st_cnt;
  logic [16:0]        alpha_reg;
  logic [16:0]        gamma_reg;
  result_t            expected_results [$];

  initial begin
    mismatches      = 0;
    results_checked = 0;
    index_errors    = 0;
    outstanding     = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // One table update; returns the expected result and updates the table copy.
  function automatic result_t predict_update(input item_t req);
    result_t            res;
    int unsigned        n_act;
    int unsigned        n_st;
    int unsigned        best;
    int unsigned        row_base;
    int unsigned        slot;
    int unsigned        i;
    longint             alpha;
    longint             gamma;
    longint             target;
    longint             delta;
    longint             updated;
    logic signed [31:0] row_max;
    logic signed [31:0] old_val;
    res     = '0;
    n_act   = (act_cnt > MAX_ACTIONS) ? MAX_ACTIONS : act_cnt;
    n_st    = (st_cnt > MAX_STATES) ? MAX_STATES : st_cnt;
    alpha   = (alpha_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(alpha_reg);
    gamma   = (gamma_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(gamma_reg);
    if (req.cur_state >= n_st || req.next_state >= n_st || req.taken_action >= n_act) begin
      res.index_error = 1'b1;
      return res;
    end
    // greedy scan of the next row, strict compare keeps the lowest index on ties
    row_base = req.next_state * MAX_ACTIONS;
    row_max  = q_values[row_base];
    best     = 0;
    for (i = 1; i < n_act; i++) begin
      if (q_values[row_base + i] > row_max) begin
        row_max = q_values[row_base + i];
        best    = i;
      end
    end
    slot    = req.cur_state * MAX_ACTIONS + req.taken_action;
    old_val = q_values[slot];
    // arithmetic shift of a signed 64-bit product is a floor divide by 2^16
    target  = longint'($signed(req.reward)) + ((gamma * longint'(row_max)) >>> 16);
    delta   = target - longint'(old_val);
    updated = longint'(old_val) + ((alpha * delta) >>> 16);
    if (updated > longint'(32'sh7FFF_FFFF)) begin
      updated = longint'(32'sh7FFF_FFFF);
    end else if (updated < -longint'(64'sd2147483648)) begin
      updated = -longint'(64'sd2147483648);
    end
    q_values[slot]       = updated[31:0];
    res.new_value        = updated[31:0];
    res.best_next_action = best[2:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    if (rst) begin
      foreach (q_values[k]) q_values[k] = '0;
      act_cnt   = 4'(ACTION_RESET);
      st_cnt    = 11'(STATE_RESET);
      alpha_reg = LEARN_RATE_RESET;
      gamma_reg = DISCOUNT_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTION_COUNT: act_cnt   = cfg_data[3:0];
          CFG_STATE_COUNT:  st_cnt    = cfg_data[10:0];
          CFG_LEARN_RATE:   alpha_reg = cfg_data[16:0];
          CFG_DISCOUNT:     gamma_reg = cfg_data[16:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unrequested result: value %0d action %0d err %0b",
                                    $signed(result_data.new_value),
                                    result_data.best_next_action, result_data.index_error));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (result_data.new_value !== want.new_value ||
              result_data.best_next_action !== want.best_next_action ||
              result_data.index_error !== want.index_error) begin
            report_mismatch($sformatf(
              "result %0d: got value %0d action %0d err %0b, want %0d %0d %0b",
              results_checked, $signed(result_data.new_value),
              result_data.best_next_action, result_data.index_error,
              $signed(want.new_value), want.best_next_action, want.index_error));
          end
        end
      end
      if (item_valid && !item_stall) begin
        pred = predict_update(item_data);
        if (pred.index_error) index_errors++;
        expected_results.push_back(pred);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: verif/tb_q_table_update_engine.sv
// Testbench top for the Q-table update engine: clock, reset, requests and register writes.
// Prediction and comparison live in q_update_checker; this module gives the verdict.
// Depends on qtue_pkg, q_table_update_engine and q_update_checker.
`timescale 1ns / 1ps

module tb_q_table_update_engine;
  import qtue_pkg::*;

  localparam int TB_MAX_STATES  = 1024;
  localparam int TB_MAX_ACTIONS = 8;
  // Slowest run: the clear pass, then 1120 requests plus heavy sender gaps
  // and result stalls; the limit allows for that several times over.
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 40;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item_data;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          outstanding;
  int          mismatches;
  int          results_checked;
  int          index_errors;

  int          send_idle_pct;   // chance per cycle that the sender holds off
  int          stall_pct;       // chance per cycle that results are stalled
  int unsigned eff_states;      // state count as the block will apply it
  int unsigned eff_actions;     // action count as the block will apply it
  int          cycle_count;
  int          settings_seen;
  int          requests_sent;

  always #5 clk = ~clk;

  q_table_update_engine dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  q_update_checker #(
    .MAX_STATES  (TB_MAX_STATES),
    .MAX_ACTIONS (TB_MAX_ACTIONS)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item_data       (item_data),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_data     (result_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .index_errors    (index_errors)
  );

  // Result-side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // One register write per cycle; the caller lowers cfg_we after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Only called with the block idle: right after reset or after a drain.
  task automatic apply_settings(input int acts, input int states, input int rate,
                                input int disc);
    write_reg(CFG_ACTION_COUNT, acts);
    write_reg(CFG_STATE_COUNT, states);
    write_reg(CFG_LEARN_RATE, rate);
    write_reg(CFG_DISCOUNT, disc);
    cfg_we      <= 1'b0;
    eff_actions = ((acts & 4'hF) > TB_MAX_ACTIONS) ? TB_MAX_ACTIONS : (acts & 4'hF);
    eff_states  = ((states & 11'h7FF) > TB_MAX_STATES) ? TB_MAX_STATES : (states & 11'h7FF);
    settings_seen++;
  endtask

  // Sender goes quiet until every pending result has come back. The first edge
  // lets the checker's pending count catch up with the last accepted request.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Valid is raised once and held, with the payload frozen, until accepted.
  // The idle draw never looks at stall.
  task automatic send_request(input item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_fields(input int s, input int a, input logic [31:0] rwd, input int s1);
    item_t req;
    req.cur_state    = s[9:0];
    req.taken_action = a[2:0];
    req.reward       = rwd;
    req.next_state   = s1[9:0];
    send_request(req);
  endtask

  // Mostly legal indices from a small pool so rows fill up, ties break and
  // values interact; a tenth are drawn over the whole field width.
  function automatic logic [9:0] pick_state(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (span == 0 || roll < 10) return 10'($urandom_range(1023));
    if (roll < 65) return 10'($urandom_range(((span < 8) ? span : 8) - 1));
    return 10'($urandom_range(span - 1));
  endfunction

  function automatic logic [31:0] pick_reward();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return $urandom;
    if (roll < 40) begin
      case ($urandom_range(4))
        0:       return SAT_POS;
        1:       return SAT_NEG;
        2:       return 32'h0;
        3:       return 32'h0001_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
  endfunction

  task automatic random_request();
    item_t req;
    req.cur_state    = pick_state(eff_states);
    req.next_state   = pick_state(eff_states);
    req.taken_action = (eff_actions == 0 || $urandom_range(9) == 0) ?
                       3'($urandom_range(7)) : 3'($urandom_range(eff_actions - 1));
    req.reward       = pick_reward();
    send_request(req);
  endtask

  // Drain, reprogram all registers, pick the idling mode, then random traffic.
  task automatic run_phase(input int acts, input int states, input int rate, input int disc,
                           input int n_req, input int idle_pct, input int stl_pct);
    drain_results();
    apply_settings(acts, states, rate, disc);
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    repeat (n_req) random_request();
  endtask

  initial begin
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    item_data     <= '0;
    result_stall  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ACTION_COUNT;
    cfg_data      <= '0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    settings_seen = 1;
    requests_sent = 0;
    eff_actions   = ACTION_RESET;
    eff_states    = STATE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings. Requests wait out the clear pass on item_stall.
    send_fields(0, 0, 32'h0, 0);             // all-zero request on a zero table
    send_fields(1023, 7, SAT_POS, 1023);     // top indices, largest reward, s == s1
    send_fields(1023, 7, SAT_NEG, 1023);     // same cell, most negative reward
    send_fields(5, 3, 32'h0001_0000, 5);     // row 5 grows at action 3
    send_fields(5, 3, 32'h0001_0000, 5);
    send_fields(6, 0, 32'hFFFF_0000, 5);     // greedy pick in row 5 is action 3
    send_fields(7, 2, 32'h0, 6);             // row 6: action 0 negative, tie 1..7 -> 1
    send_fields(512, 4, 32'h1234_5678, 1023);
    send_fields(1, 7, 32'hFFFF_FFFF, 0);
    send_fields(0, 0, 32'h0000_0001, 1);

    // Directed, alpha = gamma = 1.0 on a 16-state table: drive both
    // saturation limits, then step just past the state count on each side.
    drain_results();
    apply_settings(8, 16, ONE_Q16, ONE_Q16);
    repeat (4) send_fields(0, 0, SAT_POS, 0);
    repeat (4) send_fields(1, 1, SAT_NEG, 1);
    send_fields(16, 0, 32'h0, 0);
    send_fields(0, 0, 32'h0, 16);

    // Random phases: every register, extremes included, over all idling modes.
    run_phase(8, 1024, 6554, 58982, 150, 0, 0);
    run_phase(15, 2047, 131071, 131071, 150, 86, 0);   // counts and rates above limits
    run_phase(1, 1, 0, 0, 100, 0, 86);                 // one cell, alpha = 0
    run_phase(0, 0, 65536, 65536, 20, 30, 30);         // zero counts: all index errors
    run_phase(3, 5, 32768, 40000, 150, 0, 0);
    run_phase(8, 16, 65536, 65536, 150, 86, 0);
    run_phase(8, 1024, 1, 65535, 150, 0, 86);
    run_phase(5, 64, 20000, 60000, 150, 30, 30);
    run_phase(2, 3, 65535, 1, 80, 0, 0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests under %0d register settings, mixed sender gaps and stalls",
             requests_sent, settings_seen);
    $display("run: %0d results compared, %0d expected index errors, %0d mismatches",
             results_checked, index_errors, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
